// ===== rtl/imm_pkg.sv =====
`timescale 1ns / 1ps

package imm_pkg;

  // Matrix size and derived widths.
  localparam int MATRIX_DIM = 16;
  localparam int IDX_W      = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;
  localparam int DATA_W     = 32;
  localparam int ROW_W      = 4;
  localparam int COL_W      = 4;
  localparam int KIND_W     = 2;

  // Stream payload widths: row, col and element on the input side;
  // product, row and col on the output side.
  localparam int S_TDATA_W  = ROW_W + COL_W + DATA_W;
  localparam int M_TDATA_W  = DATA_W + ROW_W + COL_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_WR_A = 2'd0,
    KIND_WR_B = 2'd1,
    KIND_READ = 2'd2
  } kind_e;

  // Write request broadcast to every cell.
  typedef struct packed {
    logic              we_a;
    logic              we_b;
    logic [IDX_W-1:0]  a_addr;
    logic [IDX_W-1:0]  b_addr;
    logic [DATA_W-1:0] data;
  } cell_wr_t;

  // Partial sum token handed from one cell to the next.
  typedef struct packed {
    logic              vld;
    logic [DATA_W-1:0] acc;
  } chain_t;

endpackage

// ===== rtl/imm_ram.sv =====
`timescale 1ns / 1ps

module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/imm_cell.sv =====
`timescale 1ns / 1ps

// One cell holds column k of A and row k of B. It forms the term
// A[row][k] * B[k][col] once per read and adds it to the passing sum.
module imm_cell
  import imm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_wr_t         wr_i,
  input  logic [IDX_W-1:0] rd_row_i,
  input  logic [IDX_W-1:0] rd_col_i,
  input  logic             load_i,
  input  chain_t           chain_i,
  output chain_t           chain_o
);

  logic [DATA_W-1:0] a_rdata;
  logic [DATA_W-1:0] b_rdata;
  logic [DATA_W-1:0] prod_q;
  logic [DATA_W-1:0] acc_q;
  logic              vld_q;

  imm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MATRIX_DIM)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr_i.we_a),
    .waddr_i (wr_i.a_addr),
    .wdata_i (wr_i.data),
    .raddr_i (rd_row_i),
    .rdata_o (a_rdata)
  );

  imm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MATRIX_DIM)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr_i.we_b),
    .waddr_i (wr_i.b_addr),
    .wdata_i (wr_i.data),
    .raddr_i (rd_col_i),
    .rdata_o (b_rdata)
  );

  // Only the low 32 bits of the product matter, so signedness does not.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= a_rdata * b_rdata;
    end
    if (chain_i.vld) begin
      acc_q <= chain_i.acc + prod_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= chain_i.vld;
    end
  end

  assign chain_o.vld = vld_q;
  assign chain_o.acc = acc_q;

endmodule

// ===== rtl/integer_matrix_multiply_top.sv =====
`timescale 1ns / 1ps

// Integer matrix multiply engine for two MATRIX_DIM x MATRIX_DIM matrices of
// signed 32-bit elements. An input item with kind 0 or 1 in tuser writes one
// element of A or B at (row, col); the next item may follow at once. An item
// with kind 2 asks for product element (row, col) and returns one result
// item holding the dot product of row "row" of A and column "col" of B,
// wrapped to 32 bits, together with the requested row and col. Kind 3 is
// taken and ignored. The storage is split over a chain of MATRIX_DIM cells:
// cell k holds column k of A and row k of B in two small RAMs and forms its
// own product term, and the partial sum walks from cell to cell, one cell per
// cycle. A read passes through one RAM read and one multiply stage, then the
// walk of the sum along the chain, before its result item appears at the
// output. The input is not ready while a read is in flight or while its
// result waits in the last cell for the output register; a result in the
// output register does not block, so writes and a new read are taken while
// it is still pending. A read that touches an element never written returns
// an undefined value. Writes with an index at or beyond MATRIX_DIM are
// dropped, and such a read returns zero.
module integer_matrix_multiply_top
  import imm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input items.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // row[3:0], col[7:4], element[39:8]
  input  logic [KIND_W-1:0]    s_axis_tuser,  // kind[1:0]
  // Result items.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata   // product[31:0], out_row[35:32], out_col[39:36]
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Unpack the input item.
  logic [ROW_W-1:0]  s_row;
  logic [COL_W-1:0]  s_col;
  logic [DATA_W-1:0] s_element;
  kind_e             s_kind;

  assign s_row     = s_axis_tdata[ROW_W-1:0];
  assign s_col     = s_axis_tdata[ROW_W+COL_W-1:ROW_W];
  assign s_element = s_axis_tdata[S_TDATA_W-1:ROW_W+COL_W];
  assign s_kind    = kind_e'(s_axis_tuser);

  logic             accept;
  logic             in_range;
  logic [IDX_W-1:0] row_idx;
  logic [IDX_W-1:0] col_idx;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_range      = (32'(s_row) < MATRIX_DIM) && (32'(s_col) < MATRIX_DIM);
  assign row_idx       = IDX_W'(s_row);
  assign col_idx       = IDX_W'(s_col);

  logic wr_a;
  logic wr_b;
  logic rd_req;

  always_comb begin
    wr_a   = 1'b0;
    wr_b   = 1'b0;
    rd_req = 1'b0;
    case (s_kind)
      KIND_WR_A: wr_a   = accept && in_range;
      KIND_WR_B: wr_b   = accept && in_range;
      KIND_READ: rd_req = accept;
      default: begin
      end
    endcase
  end

  // Request held for the result item.
  logic [ROW_W-1:0] req_row_q;
  logic [COL_W-1:0] req_col_q;
  logic             req_ok_q;

  always_ff @(posedge clk_i) begin
    if (rd_req) begin
      req_row_q <= s_row;
      req_col_q <= s_col;
      req_ok_q  <= in_range;
    end
  end

  // The RAMs read every cycle at the input's indices; the data that comes
  // out in the LOAD state belongs to the read just accepted.
  logic   start_q;
  chain_t chain [MATRIX_DIM+1];

  assign chain[0].vld = start_q;
  assign chain[0].acc = '0;

  for (genvar gi = 0; gi < MATRIX_DIM; gi++) begin : g_cell
    cell_wr_t cell_wr;

    // A[row][col] lives in cell "col"; B[row][col] lives in cell "row".
    assign cell_wr.we_a   = wr_a && (col_idx == IDX_W'(gi));
    assign cell_wr.we_b   = wr_b && (row_idx == IDX_W'(gi));
    assign cell_wr.a_addr = row_idx;
    assign cell_wr.b_addr = col_idx;
    assign cell_wr.data   = s_element;

    imm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_i     (cell_wr),
      .rd_row_i (row_idx),
      .rd_col_i (col_idx),
      .load_i   (state_q == ST_LOAD),
      .chain_i  (chain[gi]),
      .chain_o  (chain[gi+1])
    );
  end

  // The last cell keeps its sum until the next read enters the chain, so a
  // result that cannot move to the output yet simply waits there.
  logic              out_vld_q, out_vld_d;
  logic [DATA_W-1:0] out_prod_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  logic              out_free;
  logic              out_load;
  logic              chain_done;

  assign out_free   = !out_vld_q || m_axis_tready;
  assign chain_done = chain[MATRIX_DIM].vld;

  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (rd_req) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (chain_done) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      start_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      start_q   <= (state_q == ST_LOAD);
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_prod_q <= req_ok_q ? chain[MATRIX_DIM].acc : '0;
      out_row_q  <= req_row_q;
      out_col_q  <= req_col_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_col_q, out_row_q, out_prod_q};

endmodule

// ===== rtl/imm_checker.sv =====
`timescale 1ns / 1ps

module imm_checker
  import imm_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [KIND_W-1:0]    s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic in_acc;
  logic rd_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign rd_acc = in_acc && (s_axis_tuser == KIND_READ);

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // A read occupies the engine, so the input side closes behind it.
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_acc |=> !s_axis_tready)
    else $error("input still ready after a read was accepted");

  // Writes and unused kinds never block the input.
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (s_axis_tuser != KIND_READ) |=> s_axis_tready)
    else $error("input blocked after a write item");

  // A read cannot produce its result in the next cycle.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_acc && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result item appeared too early");

endmodule

bind integer_matrix_multiply_top imm_checker u_imm_checker (.*);

// ===== tb/tb_integer_matrix_multiply_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the matrix multiply engine. Every matrix element is
// written first, so no read ever touches an element that was never written.
// A short directed part follows, then a long random mix of writes, reads and
// ignored items. The bench mirrors both matrices and forms each expected
// product when the read item is accepted. The result stream is then compared
// in order against those expectations.
module tb_integer_matrix_multiply_top;
  import imm_pkg::*;

  // Kind 3 has no member in the package enum; the engine takes and drops it.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int CELLS        = MATRIX_DIM * MATRIX_DIM;
  // Highest index plus one that the 4-bit row and col fields can reach.
  localparam int ADDR_LIM     = (MATRIX_DIM < 16) ? MATRIX_DIM : 16;
  localparam int RANDOM_ITEMS = 900;
  // No idle bursts once the queue of pending items is this short.
  localparam int CALM_TAIL    = 150;
  // The final wait covers two reads through the chain, plus margin.
  localparam int DRAIN_CYCLES = 2 * (MATRIX_DIM + 2) + 4;
  // Worst quiet stretch is one read plus an output stall plus an input gap.
  localparam int QUIET_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 40;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DATA_W-1:0] element;
    bit                drain_first;  // hold this item until no result is owed
  } mm_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] product;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } product_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // row[3:0], col[7:4], element[39:8]
  logic [KIND_W-1:0]    s_axis_tuser = '0;   // kind[1:0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // product[31:0], out_row[35:32], out_col[39:36]

  integer_matrix_multiply_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Items waiting to be sent, and the products still owed by the engine.
  mm_req_t  item_q[$];
  product_t pending_products[$];

  // Mirror of the two matrices as the engine should hold them.
  logic [DATA_W-1:0] a_store[CELLS] = '{default: '0};
  logic [DATA_W-1:0] b_store[CELLS] = '{default: '0};

  // Which elements the stimulus has already written, so reads stay legal.
  bit a_seen[CELLS] = '{default: 1'b0};
  bit b_seen[CELLS] = '{default: 1'b0};

  mm_req_t  cur_req = '{default: '0};
  product_t head_want;
  bit       sending = 1'b0;
  bit       in_taken = 1'b0;
  int       in_gap = 0;
  int       out_gap = 0;
  int       quiet_cycles = 0;
  int       mismatches = 0;
  int       n_writes = 0;
  int       n_reads = 0;
  int       n_ignored = 0;
  int       n_checked = 0;

  task automatic flag_error(input string msg);
    if (mismatches < MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic bit idling_on();
    return item_q.size() > CALM_TAIL;
  endfunction

  function automatic logic [DATA_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      4: return DATA_W'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // A read is only allowed when every element its dot product uses has been
  // written; a read outside the matrix needs nothing.
  function automatic bit read_ok(input int row, input int col);
    if (row >= MATRIX_DIM || col >= MATRIX_DIM) return 1'b1;
    for (int k = 0; k < MATRIX_DIM; k++) begin
      if (!a_seen[row * MATRIX_DIM + k] || !b_seen[k * MATRIX_DIM + col]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void queue_item(input logic [KIND_W-1:0] kind, input int row,
                                     input int col, input logic [DATA_W-1:0] element,
                                     input bit drain_first);
    mm_req_t req;
    req.kind        = kind;
    req.row         = row[ROW_W-1:0];
    req.col         = col[COL_W-1:0];
    req.element     = element;
    req.drain_first = drain_first;
    item_q.push_back(req);
    if (row < MATRIX_DIM && col < MATRIX_DIM) begin
      if (kind == KIND_WR_A) a_seen[row * MATRIX_DIM + col] = 1'b1;
      if (kind == KIND_WR_B) b_seen[row * MATRIX_DIM + col] = 1'b1;
    end
  endfunction

  function automatic logic [DATA_W-1:0] dot_product_of(input int row, input int col);
    logic [DATA_W-1:0] acc = '0;
    for (int k = 0; k < MATRIX_DIM; k++) begin
      acc = acc + a_store[row * MATRIX_DIM + k] * b_store[k * MATRIX_DIM + col];
    end
    return acc;
  endfunction

  // Apply one accepted item to the mirror; a read leaves one owed product.
  task automatic take_item(input logic [KIND_W-1:0] kind, input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col, input logic [DATA_W-1:0] element);
    product_t want;
    bit       in_range;
    in_range = (int'(row) < MATRIX_DIM) && (int'(col) < MATRIX_DIM);
    case (kind)
      KIND_WR_A: begin
        n_writes++;
        if (in_range) a_store[int'(row) * MATRIX_DIM + int'(col)] = element;
      end
      KIND_WR_B: begin
        n_writes++;
        if (in_range) b_store[int'(row) * MATRIX_DIM + int'(col)] = element;
      end
      KIND_READ: begin
        n_reads++;
        want.product = in_range ? dot_product_of(int'(row), int'(col)) : '0;
        want.row     = row;
        want.col     = col;
        pending_products.push_back(want);
      end
      default: n_ignored++;
    endcase
  endtask

  // Input side: record each accepted item. Result side: check each result
  // against the oldest owed product. Both sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        take_item(s_axis_tuser, s_axis_tdata[ROW_W-1:0],
                  s_axis_tdata[ROW_W+COL_W-1:ROW_W],
                  s_axis_tdata[S_TDATA_W-1:ROW_W+COL_W]);
        in_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_products.size() == 0) begin
          flag_error($sformatf("result %h arrived with no read outstanding", m_axis_tdata));
        end else begin
          head_want = pending_products.pop_front();
          n_checked++;
          if (m_axis_tdata[DATA_W-1:0] !== head_want.product)
            flag_error($sformatf("product (%0d,%0d): got %h, want %h", head_want.row,
                                 head_want.col, m_axis_tdata[DATA_W-1:0], head_want.product));
          if (m_axis_tdata[DATA_W+ROW_W-1:DATA_W] !== head_want.row)
            flag_error($sformatf("out_row: got %h, want %h",
                                 m_axis_tdata[DATA_W+ROW_W-1:DATA_W], head_want.row));
          if (m_axis_tdata[M_TDATA_W-1:DATA_W+ROW_W] !== head_want.col)
            flag_error($sformatf("out_col: got %h, want %h",
                                 m_axis_tdata[M_TDATA_W-1:DATA_W+ROW_W], head_want.col));
        end
      end
    end
  end

  // Sender: moves to the next item on the falling edge after the current one
  // was taken, with random idle bursts between items. An item marked
  // drain_first waits until every owed product has come back.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        sending  = 1'b0;
        in_taken = 1'b0;
      end
      if (!sending && item_q.size() != 0) begin
        if (in_gap == 0 && idling_on() && $urandom_range(0, 5) == 0)
          in_gap = $urandom_range(1, 15);
        if (in_gap != 0) begin
          in_gap--;
        end else if (!(item_q[0].drain_first && pending_products.size() != 0)) begin
          cur_req = item_q.pop_front();
          sending = 1'b1;
        end
      end
      s_axis_tvalid <= sending;
      s_axis_tuser  <= cur_req.kind;
      s_axis_tdata  <= {cur_req.element, cur_req.col, cur_req.row};
    end
  end

  // Receiver: stalls in random bursts while idling is on.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_gap == 0 && idling_on() && $urandom_range(0, 6) == 0)
        out_gap = $urandom_range(1, 15);
      if (out_gap != 0) begin
        out_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && m_axis_tready))
      quiet_cycles++;
    else
      quiet_cycles = 0;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int pick;
    int r;
    int c;

    // Fill both matrices completely so that every later read is defined.
    for (int i = 0; i < ADDR_LIM; i++) begin
      for (int j = 0; j < ADDR_LIM; j++) begin
        queue_item(KIND_WR_A, i, j, pick_element(), 1'b0);
        queue_item(KIND_WR_B, i, j, pick_element(), 1'b0);
      end
    end

    // Directed part: extreme values at the corners, corner reads, ignored
    // kind 3 items, back-to-back reads, and a read held back until idle.
    queue_item(KIND_WR_A, 0, 0, 32'h7FFF_FFFF, 1'b0);
    queue_item(KIND_WR_B, 0, 0, 32'h7FFF_FFFF, 1'b0);
    queue_item(KIND_READ, 0, 0, '0, 1'b0);
    queue_item(KIND_WR_A, 15, 15, 32'h8000_0000, 1'b0);
    queue_item(KIND_WR_B, 15, 15, 32'h8000_0000, 1'b0);
    queue_item(KIND_READ, 15, 15, '1, 1'b0);
    queue_item(KIND_READ, 0, 15, $urandom, 1'b0);
    queue_item(KIND_READ, 15, 0, $urandom, 1'b0);
    queue_item(KIND_UNUSED, 15, 15, '1, 1'b0);
    queue_item(KIND_UNUSED, 0, 0, '0, 1'b0);
    queue_item(KIND_READ, 15, 15, '0, 1'b0);
    queue_item(KIND_READ, 7, 8, $urandom, 1'b0);
    queue_item(KIND_READ, 8, 7, $urandom, 1'b0);
    queue_item(KIND_WR_A, 3, 2, '0, 1'b0);
    queue_item(KIND_WR_B, 2, 9, '1, 1'b0);
    queue_item(KIND_READ, 3, 9, $urandom, 1'b0);
    queue_item(KIND_READ, 1, 1, $urandom, 1'b1);
    queue_item(KIND_WR_A, 1, 0, '1, 1'b0);
    queue_item(KIND_READ, 1, 1, $urandom, 1'b0);

    // Random part: writes, reads, ignored items, and writes followed at
    // once by a read of a product that uses the new element.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      r    = $urandom_range(0, 15);
      c    = $urandom_range(0, 15);
      if (pick < 35) begin
        queue_item($urandom_range(0, 1) ? KIND_WR_B : KIND_WR_A, r, c, pick_element(), 1'b0);
      end else if (pick < 85) begin
        if (read_ok(r, c))
          queue_item(KIND_READ, r, c, $urandom, (i % 400) == 200);
        else
          queue_item(KIND_WR_A, r, c, pick_element(), 1'b0);
      end else if (pick < 92) begin
        queue_item(KIND_UNUSED, r, c, $urandom, 1'b0);
      end else begin
        queue_item(KIND_WR_A, r, c, pick_element(), 1'b0);
        c = $urandom_range(0, 15);
        if (read_ok(r, c)) queue_item(KIND_READ, r, c, $urandom, 1'b0);
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (item_q.size() != 0 || sending) @(posedge clk_i);
    while (pending_products.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_products.size() != 0)
      flag_error($sformatf("%0d products never arrived", pending_products.size()));

    $display("Covered %0d element writes, %0d product reads and %0d ignored items.",
             n_writes, n_reads, n_ignored);
    $display("Checked %0d results; %0d mismatches.", n_checked, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
